// ----- rtl/core/apath_pkg.sv -----
// Shared types, constants and hash helpers for the archive path hash block.
`timescale 1ns / 1ps
package apath_pkg;

  localparam logic [7:0] SlashChar     = 8'h2F;
  localparam logic [7:0] BackslashChar = 8'h5C;
  localparam logic [7:0] DotChar       = 8'h2E;
  localparam logic [7:0] UpperA        = 8'h41;
  localparam logic [7:0] UpperZ        = 8'h5A;
  localparam logic [7:0] CaseOffset    = 8'h20;

  localparam logic [31:0] ExtKf  = 32'h002E_6B66;
  localparam logic [31:0] ExtNif = 32'h2E6E_6966;
  localparam logic [31:0] ExtDds = 32'h2E64_6473;
  localparam logic [31:0] ExtWav = 32'h2E77_6176;

  localparam logic [31:0] FlagKf  = 32'h0000_0080;
  localparam logic [31:0] FlagNif = 32'h0000_8000;
  localparam logic [31:0] FlagDds = 32'h0000_8080;
  localparam logic [31:0] FlagWav = 32'h8000_0000;

  localparam logic [2:0] ExtLenMax  = 3'd5;
  localparam logic [2:0] ExtHeadLen = 3'd4;
  localparam logic [1:0] EarlyMax   = 2'd3;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       path_kind;
    logic       first_item;
    logic       no_char;
  } apath_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] byte_count;
    logic [7:0]  first_byte;
    logic [7:0]  dly0;
    logic [7:0]  dly1;
    logic [31:0] stem_hash;
    logic [31:0] ext_hash;
    logic [31:0] ext_head;
    logic [2:0]  ext_len;
    logic        dot_seen;
    logic [31:0] snap_stem;
    logic [15:0] snap_tail;
    logic [15:0] snap_len;
    logic        snap_valid;
    logic [1:0]  early;
  } apath_state_t;

  // h * 65599 + c, with 65599 = 2^16 + 2^6 - 1
  function automatic logic [31:0] sdbm_step(logic [31:0] h, logic [7:0] c);
    sdbm_step = (h << 16) + (h << 6) - h + {24'd0, c};
  endfunction

  // Last one or two bytes of the path so far, packed as the low half-word
  function automatic logic [15:0] tail_bytes(logic [1:0] early, logic [7:0] d0,
                                             logic [7:0] d1);
    if (early == 2'd0) begin
      tail_bytes = 16'd0;
    end else if (early < EarlyMax) begin
      tail_bytes = {8'd0, d0};
    end else begin
      tail_bytes = {d1, d0};
    end
  endfunction

endpackage

// ----- rtl/core/archive_path_hash.sv -----
// Top level of the archive path hash: request register, path state, result register.
`timescale 1ns / 1ps
// Takes one path byte per request and returns the 64-bit archive hash once the byte
// flagged last_item is accepted and has passed through the input register, the running
// path state and the result register. A request moves from the input register into the
// running path state, so the block sustains one byte per clock while out_ready_i does
// not hold it back; the hash is assembled from the finished state and registered while
// the next path already folds in. Only out_ready_i low holds the pipe back: a
// finished path waits for the result register before the next byte may enter the state.
module archive_path_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_byte_i,
  input  logic        path_kind_i,
  input  logic        first_item_i,
  input  logic        last_item_i,
  input  logic        no_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] path_hash_o
);
  import apath_pkg::*;

  apath_item_t  item_q;
  logic         last_q;
  logic         valid_q;
  logic         pending_q;
  logic         adv;
  logic         load;
  apath_state_t state;

  // hold the state while a finished path has not yet moved to the result register
  assign adv        = valid_q && (!pending_q || load);
  assign in_ready_o = !valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (adv) begin
        pending_q <= last_q;
      end else if (load) begin
        pending_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= '{char_byte: char_byte_i, path_kind: path_kind_i,
                  first_item: first_item_i, no_char: no_char_i};
      last_q <= last_item_i;
    end
  end

  apath_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .item_i  (item_q),
    .state_o (state)
  );

  apath_final u_final (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pending_i   (pending_q),
    .state_i     (state),
    .out_ready_i (out_ready_i),
    .load_o      (load),
    .out_valid_o (out_valid_o),
    .path_hash_o (path_hash_o)
  );

  a_state_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q && !load |-> !adv)
    else $error("path state advanced over an unfinished hash");

  a_last_pends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && last_q |=> pending_q)
    else $error("last byte did not raise a pending hash");

  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("loaded hash not presented");

endmodule

// ----- rtl/core/apath_fold.sv -----
// Running path state: folds the normalized byte of each request that carries one into the hashes.
`timescale 1ns / 1ps
module apath_fold (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  apath_pkg::apath_item_t item_i,
  output apath_pkg::apath_state_t state_o
);
  import apath_pkg::*;

  apath_state_t state_q, state_d;
  logic [7:0]   c;

  always_comb begin
    state_d = state_q;
    c       = item_i.char_byte;
    if (c == SlashChar) begin
      c = BackslashChar;
    end else if (c >= UpperA && c <= UpperZ) begin
      c = c + CaseOffset;
    end

    if (item_i.first_item) begin
      state_d      = '0;
      state_d.kind = item_i.path_kind;
    end

    if (!item_i.no_char) begin
      // a dot in a file path restarts the extension and snapshots the stem
      if (state_d.kind && c == DotChar) begin
        state_d.snap_stem = state_d.stem_hash;
        state_d.snap_tail = tail_bytes(state_d.early, state_d.dly0, state_d.dly1);
        state_d.snap_len  = state_d.byte_count;
        state_d.dot_seen  = 1'b1;
        state_d.ext_hash  = '0;
        state_d.ext_head  = '0;
        state_d.ext_len   = '0;
      end
      if (state_d.early == 2'd0) begin
        state_d.first_byte = c;
      end
      if (state_d.early == EarlyMax) begin
        state_d.stem_hash = sdbm_step(state_d.stem_hash, state_d.dly1);
      end
      state_d.dly1       = state_d.dly0;
      state_d.dly0       = c;
      state_d.byte_count = state_d.byte_count + 16'd1;
      if (state_d.early < EarlyMax) begin
        state_d.early = state_d.early + 2'd1;
      end

      if (state_d.kind && state_d.dot_seen) begin
        state_d.ext_hash = sdbm_step(state_d.ext_hash, c);
        if (state_d.ext_len < ExtHeadLen) begin
          state_d.ext_head = {state_d.ext_head[23:0], c};
        end
        if (state_d.ext_len < ExtLenMax) begin
          state_d.ext_len = state_d.ext_len + 3'd1;
        end
      end
      // folder paths snapshot on every non-separator byte to drop trailing ones
      if (!state_d.kind && c != BackslashChar) begin
        state_d.snap_stem  = state_d.stem_hash;
        state_d.snap_tail  = tail_bytes(state_d.early, state_d.dly0, state_d.dly1);
        state_d.snap_len   = state_d.byte_count;
        state_d.snap_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (adv_i) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// ----- rtl/core/apath_final.sv -----
// Hash assembly from the finished path state and the result register.
`timescale 1ns / 1ps
module apath_final (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pending_i,
  input  apath_pkg::apath_state_t state_i,
  input  logic                   out_ready_i,
  output logic                   load_o,
  output logic                   out_valid_o,
  output logic [63:0]            path_hash_o
);
  import apath_pkg::*;

  logic [31:0] upper, lower, flags;
  logic [63:0] hash_d;
  logic [63:0] hash_q;
  logic        valid_q;

  always_comb begin
    flags = '0;
    if (state_i.ext_len == 3'd3 && state_i.ext_head == ExtKf) begin
      flags = FlagKf;
    end else if (state_i.ext_len == ExtHeadLen && state_i.ext_head == ExtNif) begin
      flags = FlagNif;
    end else if (state_i.ext_len == ExtHeadLen && state_i.ext_head == ExtDds) begin
      flags = FlagDds;
    end else if (state_i.ext_len == ExtHeadLen && state_i.ext_head == ExtWav) begin
      flags = FlagWav;
    end

    upper = state_i.snap_stem;
    // the first byte overlaps the high half of the length field
    lower = {state_i.snap_len, state_i.snap_tail} | {state_i.first_byte, 24'd0};
    if (state_i.kind && !state_i.dot_seen) begin
      upper = state_i.stem_hash;
      lower = {state_i.byte_count,
               tail_bytes(state_i.early, state_i.dly0, state_i.dly1)} |
              {state_i.first_byte, 24'd0};
    end else if (state_i.kind) begin
      upper = state_i.snap_stem + state_i.ext_hash;
      lower = lower | flags;
    end

    hash_d = {upper, lower};
    if (!state_i.kind && !state_i.snap_valid) begin
      hash_d = '0;
    end else if (state_i.kind && state_i.early == 2'd0) begin
      hash_d = '0;
    end
  end

  assign load_o = pending_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      hash_q <= hash_d;
    end
  end

  assign out_valid_o = valid_q;
  assign path_hash_o = hash_q;

endmodule

// ----- tb/tb_archive_path_hash.sv -----
// Self-checking testbench for archive_path_hash: random path streams against a built-in hash predictor.
`timescale 1ns / 1ps
module tb_archive_path_hash;
  import apath_pkg::*;

  localparam int unsigned RandomTarget = 1040;
  localparam int unsigned LongStem     = 200;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned QuietLimit   = 3000;
  localparam int unsigned MaxReports   = 20;

  // Emission styles for one path
  localparam int unsigned StyleClean     = 0;
  localparam int unsigned StyleNoFirst   = 1;
  localparam int unsigned StyleBlankLast = 2;
  localparam int unsigned StyleBlankMid  = 3;
  localparam int unsigned StyleBlankHead = 4;

  typedef struct packed {
    logic [7:0] ch;
    logic       kind;
    logic       first;
    logic       last;
    logic       blank;
  } path_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_byte_i = 8'd0;
  logic        path_kind_i = 1'b0;
  logic        first_item_i = 1'b0;
  logic        last_item_i = 1'b0;
  logic        no_char_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] path_hash_o;

  archive_path_hash i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_byte_i (char_byte_i),
    .path_kind_i (path_kind_i),
    .first_item_i(first_item_i),
    .last_item_i (last_item_i),
    .no_char_i   (no_char_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .path_hash_o (path_hash_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  path_req_t   req_q[$];
  logic [63:0] hashes_due_q[$];
  int unsigned n_queued = 0;
  int unsigned n_bytes_in = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;

  // Path hash predictor state
  logic        kind_q = 1'b0;
  logic [15:0] count_q = '0;
  logic [7:0]  head_byte_q = '0;
  logic [7:0]  prev0_q = '0;
  logic [7:0]  prev1_q = '0;
  logic [31:0] stem_h_q = '0;
  logic [31:0] ext_h_q = '0;
  logic [31:0] ext_head_q = '0;
  logic [2:0]  ext_len_q = '0;
  logic        dot_q = 1'b0;
  logic [31:0] cut_stem_h_q = '0;
  logic [15:0] cut_tail_q = '0;
  logic [15:0] cut_len_q = '0;
  logic        cut_valid_q = 1'b0;
  logic [1:0]  seen_q = '0;

  function automatic logic [31:0] sdbm_fold(logic [31:0] h, logic [7:0] c);
    return h * 32'd65599 + {24'd0, c};
  endfunction

  function automatic logic [15:0] recent_pair();
    if (seen_q == 2'd0) return 16'd0;
    if (seen_q < EarlyMax) return {8'd0, prev0_q};
    return {prev1_q, prev0_q};
  endfunction

  task automatic clear_path_state();
    count_q = '0; head_byte_q = '0; prev0_q = '0; prev1_q = '0;
    stem_h_q = '0; ext_h_q = '0; ext_head_q = '0; ext_len_q = '0; dot_q = 1'b0;
    cut_stem_h_q = '0; cut_tail_q = '0; cut_len_q = '0; cut_valid_q = 1'b0;
    seen_q = '0;
  endtask

  task automatic take_cut();
    cut_stem_h_q = stem_h_q;
    cut_tail_q   = recent_pair();
    cut_len_q    = count_q;
  endtask

  task automatic fold_byte(input logic [7:0] raw);
    logic [7:0] c;
    c = raw;
    if (c == SlashChar) c = BackslashChar;
    else if (c >= UpperA && c <= UpperZ) c = c + CaseOffset;
    if (kind_q && c == DotChar) begin
      take_cut();
      dot_q = 1'b1;
      ext_h_q = '0; ext_head_q = '0; ext_len_q = '0;
    end
    if (seen_q == 2'd0) head_byte_q = c;
    if (seen_q == EarlyMax) stem_h_q = sdbm_fold(stem_h_q, prev1_q);
    prev1_q = prev0_q;
    prev0_q = c;
    count_q = count_q + 16'd1;
    if (seen_q < EarlyMax) seen_q = seen_q + 2'd1;
    if (kind_q && dot_q) begin
      ext_h_q = sdbm_fold(ext_h_q, c);
      if (ext_len_q < ExtHeadLen) ext_head_q = {ext_head_q[23:0], c};
      if (ext_len_q < ExtLenMax) ext_len_q = ext_len_q + 3'd1;
    end
    if (!kind_q && c != BackslashChar) begin
      take_cut();
      cut_valid_q = 1'b1;
    end
  endtask

  function automatic logic [63:0] path_digest();
    logic [31:0] upper;
    logic [31:0] lower;
    if (!kind_q) begin
      if (!cut_valid_q) return 64'd0;
      upper = cut_stem_h_q;
      lower = {16'd0, cut_tail_q} | {cut_len_q, 16'd0} | {head_byte_q, 24'd0};
    end else begin
      if (seen_q == 2'd0) return 64'd0;
      if (dot_q) begin
        upper = cut_stem_h_q + ext_h_q;
        lower = {16'd0, cut_tail_q} | {cut_len_q, 16'd0} | {head_byte_q, 24'd0};
        if (ext_len_q == 3'd3 && ext_head_q == ExtKf) lower |= FlagKf;
        else if (ext_len_q == ExtHeadLen && ext_head_q == ExtNif) lower |= FlagNif;
        else if (ext_len_q == ExtHeadLen && ext_head_q == ExtDds) lower |= FlagDds;
        else if (ext_len_q == ExtHeadLen && ext_head_q == ExtWav) lower |= FlagWav;
      end else begin
        upper = stem_h_q;
        lower = {16'd0, recent_pair()} | {count_q, 16'd0} | {head_byte_q, 24'd0};
      end
    end
    return {upper, lower};
  endfunction

  task automatic absorb_request(input path_req_t r);
    if (r.first) begin
      clear_path_state();
      kind_q = r.kind;
    end
    if (!r.blank) fold_byte(r.ch);
    if (r.last) hashes_due_q.push_back(path_digest());
  endtask

  // Stimulus builders
  task automatic push_req(input logic [7:0] ch, input logic kind, input logic first,
                          input logic last, input logic blank);
    path_req_t r;
    r.ch = ch; r.kind = kind; r.first = first; r.last = last; r.blank = blank;
    req_q.push_back(r);
    n_queued++;
  endtask

  task automatic emit_path(input logic kind, ref logic [7:0] body[$],
                           input int unsigned style);
    int unsigned n;
    n = body.size();
    if (n == 0) begin
      push_req(8'($urandom), kind, 1'b1, 1'b1, 1'b1);
      return;
    end
    if (style == StyleBlankHead) push_req(8'($urandom), kind, 1'b1, 1'b0, 1'b1);
    for (int unsigned i = 0; i < n; i++) begin
      if (style == StyleBlankMid && $urandom_range(0, 3) == 0)
        push_req(8'($urandom), 1'($urandom), 1'b0, 1'b0, 1'b1);
      push_req(body[i], (i == 0) ? kind : 1'($urandom),
               i == 0 && style != StyleNoFirst && style != StyleBlankHead,
               i == n - 1 && style != StyleBlankLast, 1'b0);
    end
    if (style == StyleBlankLast) push_req(8'($urandom), 1'($urandom), 1'b0, 1'b1, 1'b1);
  endtask

  // Append text, flipping letters to upper case now and then
  task automatic append_text(ref logic [7:0] body[$], input string s, input bit vary);
    logic [7:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (vary && ch >= "a" && ch <= "z" && $urandom_range(0, 3) == 0) ch = ch - 8'h20;
      body.push_back(ch);
    end
  endtask

  task automatic send_text(input logic kind, input string s);
    logic [7:0] body[$];
    append_text(body, s, 1'b0);
    emit_path(kind, body, StyleClean);
  endtask

  function automatic logic [7:0] path_char();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 8'(8'h61 + $urandom_range(0, 25));
    if (pick < 55) return 8'(8'h41 + $urandom_range(0, 25));
    if (pick < 64) return SlashChar;
    if (pick < 71) return BackslashChar;
    if (pick < 78) return DotChar;
    if (pick < 86) begin
      case ($urandom_range(0, 5))
        0: return 8'h40;
        1: return 8'h5B;
        2: return UpperA;
        3: return UpperZ;
        4: return 8'h60;
        default: return 8'h7B;
      endcase
    end
    return 8'($urandom);
  endfunction

  task automatic send_random_path();
    logic [7:0] body[$];
    logic kind;
    int unsigned stem_len;
    int unsigned pick;
    int unsigned style;
    kind = ($urandom_range(0, 9) < 6);
    stem_len = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
    for (int unsigned i = 0; i < stem_len; i++) body.push_back(path_char());
    if (kind) begin
      case ($urandom_range(0, 7))
        0: append_text(body, ".kf", 1'b1);
        1: append_text(body, ".nif", 1'b1);
        2: append_text(body, ".dds", 1'b1);
        3: append_text(body, ".wav", 1'b1);
        4, 5: begin
          body.push_back(DotChar);
          for (int unsigned i = $urandom_range(0, 5); i > 0; i--) body.push_back(path_char());
        end
        default: ;
      endcase
    end else if ($urandom_range(0, 1) == 0) begin
      for (int unsigned i = $urandom_range(1, 3); i > 0; i--)
        body.push_back($urandom_range(0, 1) ? SlashChar : BackslashChar);
    end
    pick = $urandom_range(0, 19);
    style = (pick <= StyleBlankHead) ? pick : StyleClean;
    emit_path(kind, body, style);
    // occasional garbage between paths
    if ($urandom_range(0, 19) == 0) begin
      for (int unsigned i = $urandom_range(1, 4); i > 0; i--)
        push_req(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // Request driver
  logic        in_burst = 1'b0;
  int unsigned in_gap_left = 0;
  path_req_t   held_req;

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    path_req_t   nxt;
    int unsigned gap;
    logic        load;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      in_gap_left <= 0;
    end else begin
      load = 1'b0;
      if (in_valid_i && in_ready_o) begin
        absorb_request(held_req);
        n_bytes_in++;
        if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 4);
        if (gap == 0 && req_q.size() != 0) begin
          load = 1'b1;
        end else begin
          in_valid_i  <= 1'b0;
          in_gap_left <= gap;
        end
      end else if (!in_valid_i) begin
        if (in_gap_left != 0) in_gap_left <= in_gap_left - 1;
        else if (req_q.size() != 0) load = 1'b1;
      end
      if (load) begin
        nxt = req_q.pop_front();
        held_req = nxt;
        in_valid_i   <= 1'b1;
        char_byte_i  <= nxt.ch;
        path_kind_i  <= nxt.kind;
        first_item_i <= nxt.first;
        last_item_i  <= nxt.last;
        no_char_i    <= nxt.blank;
      end
    end
  end

  // Hash collector: random stalls, plus a long hold-off now and then
  logic        out_burst = 1'b0;
  int unsigned out_stall_left = 0;
  int unsigned out_hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : collect_hashes
    logic [63:0] want;
    int unsigned stall;
    if (!rst_ni) begin
      out_ready_i    <= 1'b0;
      out_stall_left <= 0;
      out_hold_left  <= 0;
    end else if (out_valid_o && out_ready_i) begin
      n_results++;
      if (hashes_due_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports)
          $display("%0t: unexpected hash, expected none actual %h", $time, path_hash_o);
      end else begin
        want = hashes_due_q.pop_front();
        if (path_hash_o !== want) begin
          n_errors++;
          if (n_errors <= MaxReports)
            $display("%0t: path_hash mismatch, expected %h actual %h", $time, want,
                     path_hash_o);
        end
      end
      if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 4);
      if (n_results % 500 == 30) begin
        out_ready_i   <= 1'b0;
        out_hold_left <= HoldCycles;
      end else if (stall != 0) begin
        out_ready_i    <= 1'b0;
        out_stall_left <= stall;
      end
    end else if (out_hold_left != 0) begin
      out_hold_left <= out_hold_left - 1;
    end else if (out_stall_left != 0) begin
      out_stall_left <= out_stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Abort when no request and no hash moves for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d hashes outstanding", $time,
                 QuietLimit, hashes_due_q.size());
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : run_paths
    logic [7:0] long_body[$];
    send_text(1'b0, "");        // empty path
    send_text(1'b1, "A.KF");    // upper case, short stem, kf flag
    send_text(1'b1, ".dds");    // empty stem
    send_text(1'b0, "/");       // folder of separators only
    send_text(1'b0, "Ab//");    // trailing separators dropped
    send_text(1'b1, "x.nif");
    send_text(1'b1, "b.WAV");
    // high byte continuing the finished path without a first flag
    push_req(8'hFF, 1'b1, 1'b0, 1'b1, 1'b0);
    while (n_queued < RandomTarget) send_random_path();
    // one long stem with a nif extension
    for (int unsigned i = 0; i < LongStem; i++) long_body.push_back(8'(8'h61 + $urandom_range(0, 25)));
    append_text(long_body, ".nif", 1'b0);
    emit_path(1'b1, long_body, StyleClean);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (req_q.size() != 0 || in_valid_i || hashes_due_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d path requests (folder, file, blank, unflagged and garbage items,",
             n_bytes_in);
    $display("one %0d-byte path); checked %0d hashes, %0d errors", LongStem + 4, n_results,
             n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
